>>> rtl/mfde_pkg.sv
`timescale 1ns / 1ps
package mfde_pkg;

  localparam int DefMaxWidth   = 1024;
  localparam int DefMaxHeight  = 1024;
  localparam int DefStoreBytes = 131072;

  localparam int CfgWidth = 11;

  typedef enum logic [2:0] {
    CMD_CLEAR   = 3'd0,
    CMD_SET     = 3'd1,
    CMD_READ    = 3'd2,
    CMD_FILL    = 3'd3,
    CMD_OUTLINE = 3'd4,
    CMD_GLYPH   = 3'd5
  } cmd_t;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
    logic               draw_black;
    logic [7:0]         glyph_scale;
    logic [63:0]        glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic pixel_black;
    logic in_bounds;
  } out_item_t;

  // One clipped rectangle handed to the span walker
  typedef struct packed {
    logic [11:0] x0;
    logic [11:0] x1;
    logic [11:0] y0;
    logic [11:0] y1;
  } span_req_t;

endpackage

>>> rtl/mono_framebuffer_draw_engine_core.sv
`timescale 1ns / 1ps
// 1-bit framebuffer drawing engine. One command item in, one result item out.
// The frame lives in a byte RAM (stride ceil(width/8), MSB-first pixels, 0 =
// black). Every command but clear is reduced to clipped rectangles that are
// walked one byte at a time: each byte costs a read, a modify and a write,
// with the RAM port as the limiting resource. Clear only writes, byte by byte
// over stride*height bytes. An outline is four rectangles, a glyph up to 64
// squares. The store is not cleared at reset; issue a clear before reading.
// The result item is returned after the last write (for a read, the read) of
// its command; the next item is taken only once the result has been accepted.
module mono_framebuffer_draw_engine_core #(
  parameter int MaxWidth   = mfde_pkg::DefMaxWidth,
  parameter int MaxHeight  = mfde_pkg::DefMaxHeight,
  parameter int StoreBytes = mfde_pkg::DefStoreBytes
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [10:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mfde_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mfde_pkg::out_item_t  out_item
);
  import mfde_pkg::*;

  localparam int AW = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PLAN  = 9'b000000010,
    S_CLR   = 9'b000000100,
    S_RD    = 9'b000001000,
    S_WAIT  = 9'b000010000,
    S_WR    = 9'b000100000,
    S_NEXT  = 9'b001000000,
    S_PRD   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic [10:0] frame_width, frame_height;
  in_item_t    item;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= '0;
      frame_height <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FRAME_WIDTH) frame_width <= cfg_data;
      else frame_height <= cfg_data;
    end
  end

  // Effective frame size
  logic [8:0]  stride;
  logic [19:0] need;
  logic        fits;
  logic [11:0] fw, fh;
  assign stride = 9'((12'(frame_width) + 12'd7) >> 3);
  assign need   = 20'(stride) * 20'(frame_height);
  assign fits   = (32'(frame_width) <= 32'(MaxWidth)) &&
                  (32'(frame_height) <= 32'(MaxHeight)) &&
                  (32'(need) <= 32'(StoreBytes));
  assign fw = fits ? 12'(frame_width) : 12'd0;
  assign fh = fits ? 12'(frame_height) : 12'd0;

  // Rectangle source: piece counter over outline sides / glyph cells
  logic [6:0]  piece;
  logic signed [18:0] rx, ry, rw, rh;
  logic        pvalid;
  logic [2:0]  gc, gr;
  logic signed [18:0] sc;

  assign gc = piece[2:0];
  assign gr = piece[5:3];
  assign sc = 19'($signed({1'b0, item.glyph_scale}));

  always_comb begin
    rx = 19'(item.pos_x);
    ry = 19'(item.pos_y);
    rw = 19'(item.rect_w);
    rh = 19'(item.rect_h);
    pvalid = 1'b1;
    case (item.cmd)
      CMD_SET, CMD_READ: begin
        rw = 19'sd1;
        rh = 19'sd1;
      end
      CMD_FILL: ;
      CMD_OUTLINE: begin
        case (piece[1:0])
          2'd0: rh = 19'sd1;
          2'd1: begin
            ry = 19'(item.pos_y) + 19'(item.rect_h) - 19'sd1;
            pvalid = (item.rect_h > 0);
            rh = 19'sd1;
          end
          2'd2: rw = 19'sd1;
          default: begin
            rx = 19'(item.pos_x) + 19'(item.rect_w) - 19'sd1;
            pvalid = (item.rect_w > 0);
            rw = 19'sd1;
          end
        endcase
        pvalid = pvalid && (item.rect_w > 0) && (item.rect_h > 0);
      end
      CMD_GLYPH: begin
        // scale * index; index 3 bits
        rx = 19'(item.pos_x) + 19'(sc * $signed({16'd0, gc}));
        ry = 19'(item.pos_y) + 19'(sc * $signed({16'd0, gr}));
        rw = sc;
        rh = sc;
        pvalid = item.glyph_bits[{gr, gc}];
      end
      default: pvalid = 1'b0;
    endcase
  end

  // Clip the current piece; negative ends are tested before the unsigned bound
  span_req_t   span;
  logic        span_ok;
  logic signed [19:0] ex, ey;
  always_comb begin
    ex = 20'(rx) + 20'(rw);
    ey = 20'(ry) + 20'(rh);
    span.x0 = (rx < 0) ? 12'd0 : ((rx > 19'(fw)) ? fw : 12'(rx));
    span.y0 = (ry < 0) ? 12'd0 : ((ry > 19'(fh)) ? fh : 12'(ry));
    span.x1 = (ex < 0) ? 12'd0 : ((ex > 20'(fw)) ? fw : 12'(ex));
    span.y1 = (ey < 0) ? 12'd0 : ((ey > 20'(fh)) ? fh : 12'(ey));
    span_ok = pvalid && (rw > 0) && (rh > 0) && (span.x0 < span.x1) &&
              (span.y0 < span.y1);
  end

  logic [6:0] piece_last;
  always_comb begin
    case (item.cmd)
      CMD_OUTLINE: piece_last = 7'd3;
      CMD_GLYPH:   piece_last = (item.glyph_scale == 8'd0) ? 7'd0 : 7'd63;
      default:     piece_last = 7'd0;
    endcase
  end

  // Walker registers
  span_req_t  cur;
  logic [8:0] bx;        // byte column
  logic [11:0] py;
  logic [AW-1:0] row_base, addr;
  logic [19:0] clr_cnt;
  logic [7:0]  rdata, wmask, wdata;
  logic        we;
  logic        rd_black, rd_in;

  assign addr = AW'(20'(row_base) + 20'(bx));

  // Mask of pixels of byte bx covered by [x0, x1)
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      wmask[7-i] = ({bx, 3'(i)} >= cur.x0) && ({bx, 3'(i)} < cur.x1);
    end
  end
  assign wdata = item.draw_black ? (rdata & ~wmask) : (rdata | wmask);

  // Clear writes only bytes inside the frame; a read never writes
  logic [AW-1:0] waddr;
  logic [7:0]    ram_wdata;
  always_comb begin
    we        = 1'b0;
    waddr     = addr;
    ram_wdata = wdata;
    if (state == S_CLR) begin
      we = fits && (clr_cnt < need);
      waddr = AW'(clr_cnt);
      ram_wdata = item.draw_black ? 8'h00 : 8'hff;
    end else if (state == S_WR && item.cmd != CMD_READ) begin
      we = 1'b1;
    end
  end

  mfde_ram #(.Width(8), .Depth(StoreBytes)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      piece     <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          item     <= in_item;
          piece    <= '0;
          clr_cnt  <= '0;
          rd_black <= 1'b0;
          rd_in    <= 1'b0;
          state    <= (in_item.cmd == CMD_CLEAR) ? S_CLR : S_PLAN;
        end
        S_CLR: begin
          if (clr_cnt >= need || !fits) state <= S_DONE;
          else clr_cnt <= clr_cnt + 20'd1;
        end
        S_PLAN: begin
          if (span_ok) begin
            cur      <= span;
            bx       <= span.x0[11:3];
            py       <= span.y0;
            row_base <= AW'(20'(span.y0) * 20'(stride));
            state    <= (item.cmd == CMD_READ) ? S_PRD : S_RD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_RD:   state <= S_WAIT;
        S_WAIT: state <= S_WR;
        S_PRD:  state <= S_WAIT;
        S_WR: begin
          if (item.cmd == CMD_READ) begin
            rd_black <= ~|(rdata & wmask);
            rd_in    <= 1'b1;
            state    <= S_DONE;
          end else if (bx != 9'((cur.x1 - 12'd1) >> 3)) begin
            bx    <= bx + 9'd1;
            state <= S_RD;
          end else if (py + 12'd1 < cur.y1) begin
            py       <= py + 12'd1;
            bx       <= cur.x0[11:3];
            row_base <= row_base + AW'(stride);
            state    <= S_RD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (piece >= piece_last) state <= S_DONE;
          else begin
            piece <= piece + 7'd1;
            state <= S_PLAN;
          end
        end
        S_DONE: begin
          out_item.pixel_black <= rd_black;
          out_item.in_bounds   <= rd_in;
          out_valid            <= 1'b1;
          state                <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A read never writes the store
  assert property (@(posedge clk) disable iff (rst)
    (item.cmd == CMD_READ && state != S_IDLE) |-> !we)
    else $error("read command wrote the store");
  // No new item while a result is pending
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken with result pending");
  // Every write of a walk follows its read, with the wait state between them
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> $past(state, 2) == S_RD || $past(state, 2) == S_PRD)
    else $error("write without matching read");
  // Walk stays inside the clipped span
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (py < cur.y1) && ({bx, 3'd7} >= cur.x0))
    else $error("walker left span");

endmodule

>>> rtl/mfde_ram.sv
`timescale 1ns / 1ps
module mfde_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
